[sv/crpf_pkg.sv]
package crpf_pkg;

  localparam int SITE_DEPTH_DEF = 64;

  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W - 1;
  localparam int SUM_W   = SQ_W + 2;
  localparam int CUT_W   = 44;
  localparam int THR_W   = 15;
  localparam int CHG_W   = 16;
  localparam int IDX_W   = 16;
  localparam int TOT_W   = 16;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W = 1;

  // distance unit pipeline stages: diff, square, sum/compare
  localparam int DIST_LAT = 3;

  localparam logic [THR_W-1:0] THR_RESET = 15'd410;
  localparam logic [TOT_W-1:0] TOT_MAX   = '1;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TEST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic append;
    logic rotate;
  } cell_ctl_t;

endpackage

[sv/crpf_if.sv]
interface crpf_in_if import crpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic signed [CHG_W-1:0]  charge;
  logic [IDX_W-1:0]         residue_index;

  modport source (output valid, func, coord_x, coord_y, coord_z, charge, residue_index,
                  input ready);
  modport sink (input valid, func, coord_x, coord_y, coord_z, charge, residue_index,
                output ready);
endinterface

interface crpf_out_if import crpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kept;
  logic [IDX_W-1:0] kept_residue;
  logic [TOT_W-1:0] kept_total;
  logic             status;

  modport source (output valid, kept, kept_residue, kept_total, status, input ready);
  modport sink (input valid, kept, kept_residue, kept_total, status, output ready);
endinterface

[sv/charged_residue_proximity_filter.sv]
// channel   | dir | handshake     | payload
// in_ch     | in  | valid/ready   | func, coord_x/y/z, charge, residue_index
// out_ch    | out | valid/ready   | kept, kept_residue, kept_total, status
// cfg       | in  | cfg_write     | cfg_index, cfg_data (no read-back)
//
// Clear, append and unused func: accept leads to DONE, which loads the result register once it is free.
// Test: the stored points rotate once through the cell row (SCAN), one point a cycle
// into a 3-stage distance unit, then DRAIN empties it before DONE. Uncharged residues or
// an empty table skip the rotation and go straight to DONE.
// Reset (rst, synchronous) empties the table, zeroes the count, loads defaults.
// A result waiting on out_ch does not block the next accept.
module charged_residue_proximity_filter import crpf_pkg::*; #(
  parameter int SITE_DEPTH = SITE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  crpf_in_if.sink              in_ch,
  crpf_out_if.source           out_ch,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CUT_W-1:0]     cfg_data
);

  localparam int CW = $clog2(SITE_DEPTH + 1);
  localparam int KW = (SITE_DEPTH > 1) ? $clog2(SITE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state;
  logic [CW-1:0]    site_count;
  logic [TOT_W-1:0] kept_counter;
  logic [TOT_W-1:0] kept_counter_next;
  logic [CUT_W-1:0] cutoff_squared;
  logic [THR_W-1:0] charge_threshold;
  logic [KW-1:0]    scan_pos;
  logic [1:0]       drain;
  logic             hit;
  logic             dist_hit;
  logic             out_valid;
  logic             accept;
  logic             full;
  logic             charged;
  logic             entry_valid;
  logic [CHG_W-1:0] charge_mag;
  point_t           query;
  point_t           new_point;
  logic [IDX_W-1:0] query_index;
  logic             query_status;
  cell_ctl_t        ctl;
  point_t           points [SITE_DEPTH];

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (site_count == CW'(SITE_DEPTH));
  assign charge_mag  = in_ch.charge[CHG_W-1] ? (~in_ch.charge + 1'b1) : in_ch.charge;
  assign charged     = (charge_mag >= {1'b0, charge_threshold});
  assign new_point   = '{x: in_ch.coord_x, y: in_ch.coord_y, z: in_ch.coord_z};

  // valid points sit in cells 0..count-1; the tail sees them at the end of the pass
  assign entry_valid = ({1'b0, CW'(scan_pos)} + {1'b0, site_count}) >= (CW+1)'(SITE_DEPTH);

  assign ctl.append = accept && (in_ch.func == FN_APPEND) && !full;
  assign ctl.rotate = (state == ST_SCAN);

  assign kept_counter_next = (hit && kept_counter != TOT_MAX) ? kept_counter + 1'b1
                                                              : kept_counter;

  for (genvar i = 0; i < SITE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      crpf_cell #(.IS_HEAD(1'b1)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_point (new_point),
        .point_in  (points[SITE_DEPTH-1]),
        .point     (points[i])
      );
    end else begin : g_body
      crpf_cell #(.IS_HEAD(1'b0)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_point (new_point),
        .point_in  (points[i-1]),
        .point     (points[i])
      );
    end
  end

  crpf_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .go     (ctl.rotate && entry_valid),
    .query  (query),
    .site   (points[SITE_DEPTH-1]),
    .cutoff (cutoff_squared),
    .hit    (dist_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      site_count       <= '0;
      kept_counter     <= '0;
      cutoff_squared   <= '0;
      charge_threshold <= THR_RESET;
      scan_pos         <= '0;
      drain            <= '0;
      hit              <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CUTOFF: cutoff_squared   <= cfg_data;
          CFG_THRESH: charge_threshold <= cfg_data[THR_W-1:0];
          default:    ;
        endcase
      end
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            hit      <= 1'b0;
            scan_pos <= '0;
            drain    <= '0;
            if (in_ch.func == FN_CLEAR) begin
              site_count   <= '0;
              kept_counter <= '0;
            end
            if (ctl.append) begin
              site_count <= site_count + 1'b1;
            end
            if (in_ch.func == FN_TEST && charged && site_count != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          hit      <= hit | dist_hit;
          scan_pos <= scan_pos + 1'b1;
          if (scan_pos == KW'(SITE_DEPTH - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          hit   <= hit | dist_hit;
          drain <= drain + 1'b1;
          if (drain == 2'(DIST_LAT - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register frees up
          if (!out_valid || out_ch.ready) begin
            out_valid    <= 1'b1;
            kept_counter <= kept_counter_next;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query        <= new_point;
      query_index  <= in_ch.residue_index;
      query_status <= (in_ch.func == FN_APPEND) && full;
    end
    if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      out_ch.kept         <= hit;
      out_ch.kept_residue <= hit ? query_index : '0;
      out_ch.kept_total   <= kept_counter_next;
      out_ch.status       <= query_status;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

[sv/crpf_cell.sv]
module crpf_cell import crpf_pkg::*; #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  point_t    new_point,
  input  point_t    point_in,
  output point_t    point
);

  // append pushes a new point in at the head; rotate circulates the row
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      point <= IS_HEAD ? new_point : point_in;
    end else if (ctl.rotate) begin
      point <= point_in;
    end
  end

endmodule

[sv/crpf_dist.sv]
module crpf_dist import crpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  point_t           query,
  input  point_t           site,
  input  logic [CUT_W-1:0] cutoff,
  output logic             hit
);

  logic                     v1;
  logic                     v2;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic [SQ_W-1:0]          sx;
  logic [SQ_W-1:0]          sy;
  logic [SQ_W-1:0]          sz;
  logic signed [2*DIFF_W-1:0] px;
  logic signed [2*DIFF_W-1:0] py;
  logic signed [2*DIFF_W-1:0] pz;
  logic [SUM_W-1:0]         sum;

  assign px  = dx * dx;
  assign py  = dy * dy;
  assign pz  = dz * dz;
  assign sum = {2'b00, sx} + {2'b00, sy} + {2'b00, sz};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= go;
      v2  <= v1;
      hit <= v2 && ({{(CUT_W-SUM_W){1'b0}}, sum} <= cutoff);
    end
  end

  always_ff @(posedge clk) begin
    dx <= {query.x[COORD_W-1], query.x} - {site.x[COORD_W-1], site.x};
    dy <= {query.y[COORD_W-1], query.y} - {site.y[COORD_W-1], site.y};
    dz <= {query.z[COORD_W-1], query.z} - {site.z[COORD_W-1], site.z};
    // squares are never negative and fit below the sign bit
    sx <= px[SQ_W-1:0];
    sy <= py[SQ_W-1:0];
    sz <= pz[SQ_W-1:0];
  end

endmodule

[sv/crpf_checker.sv]
module crpf_checker import crpf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             kept,
  input logic [IDX_W-1:0] kept_residue,
  input logic [TOT_W-1:0] kept_total,
  input logic             status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kept_total) && $stable(kept_residue))
    else $error("result changed while stalled");

  a_drop_not_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !kept)
    else $error("dropped append reported as kept");

  a_residue_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kept |-> kept_residue == '0)
    else $error("residue echoed without keep");

  a_total_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && kept |-> kept_total != '0)
    else $error("kept residue not counted");

endmodule

bind charged_residue_proximity_filter crpf_checker u_crpf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kept         (out_ch.kept),
  .kept_residue (out_ch.kept_residue),
  .kept_total   (out_ch.kept_total),
  .status       (out_ch.status)
);
